@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define PNZ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PNZ_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/pnz_pkg.sv @@
// Constants, types and lookup tables of the 2D Perlin noise evaluator.
package pnz_pkg;

    localparam int TABLE_ENTRIES = 255;
    localparam int FRAC_BITS     = 8;
    localparam int Q_BITS        = 16;
    localparam int COORD_W       = 16;
    localparam int INT_W         = COORD_W - FRAC_BITS;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int VAL_W         = 8;
    localparam int ONE_Q16       = 1 << Q_BITS;
    localparam int HALF_Q16      = 1 << (Q_BITS - 1);
    localparam int FADE_A        = 6;
    localparam int FADE_B        = 15;
    localparam int FADE_C        = 10;

    typedef logic [IDX_W-1:0] idx_t;
    typedef idx_t int_lut_t [2**INT_W];
    typedef idx_t val_lut_t [2**VAL_W];

    // Gradient select taken from the low bits of a hash.
    typedef enum logic [1:0] {
        GRAD_PP = 2'd0,
        GRAD_NP = 2'd1,
        GRAD_PN = 2'd2,
        GRAD_NN = 2'd3
    } grad_sel_t;

    // Command codes of an input word.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    function automatic int_lut_t build_int_lut();
        int_lut_t lut;
        for (int i = 0; i < 2**INT_W; i++)
        begin
            lut[i] = IDX_W'(i % TABLE_ENTRIES);
        end
        return lut;
    endfunction

    function automatic val_lut_t build_val_lut();
        val_lut_t lut;
        for (int i = 0; i < 2**VAL_W; i++)
        begin
            lut[i] = IDX_W'(i % TABLE_ENTRIES);
        end
        return lut;
    endfunction

    // Integer part and table value reduced modulo the table size.
    localparam int_lut_t INT_MOD_LUT = build_int_lut();
    localparam val_lut_t VAL_MOD_LUT = build_val_lut();

    // Wrap a sum below twice the table size back into the table.
    function automatic idx_t wrap_idx(input logic [IDX_W:0] s);
        idx_t r;
        if (s >= (IDX_W+1)'(TABLE_ENTRIES))
        begin
            r = IDX_W'(s - (IDX_W+1)'(TABLE_ENTRIES));
        end
        else
        begin
            r = s[IDX_W-1:0];
        end
        return r;
    endfunction

    // Diagonal gradient dotted with the corner offset.
    function automatic logic signed [18:0] grad_dot(
        input logic [VAL_W-1:0]  hash,
        input logic signed [17:0] dx,
        input logic signed [17:0] dy
    );
        logic signed [18:0] ex;
        logic signed [18:0] ey;
        logic signed [18:0] r;
        ex = 19'(dx);
        ey = 19'(dy);
        case (grad_sel_t'(hash[1:0]))
            GRAD_PP: r = ex + ey;
            GRAD_NP: r = ey - ex;
            GRAD_PN: r = ex - ey;
            GRAD_NN: r = -ex - ey;
            default: r = ex + ey;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/pnz_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pnz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, then read of the old contents on the same edge.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/perlin_noise_2d_eval_top.sv @@
// Top level of the 2D Perlin noise evaluator.
//
// One word enters per clock while in_ready is high: a load word (cmd=0) writes
// one permutation entry, an evaluate word (cmd=1) gives one noise_value. The
// sustained rate is one word per clock while results are taken, set by six copies
// of the permutation table (two for the cell row lookup, four for the corner
// hashes), each with one write and one registered read port; a load writes
// all copies at once. The pipeline moves as a whole: it holds while a result
// sits in the output register and is not taken. Table entries are undefined
// after reset and must be loaded before an evaluate reads them.
`include "assert_macros.svh"

module perlin_noise_2d_eval_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [pnz_pkg::COORD_W-1:0]       x_coord,
    input  logic [pnz_pkg::COORD_W-1:0]       y_coord,
    input  logic [pnz_pkg::VAL_W-1:0]         entry_index,
    input  logic [pnz_pkg::VAL_W-1:0]         entry_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [15:0]                       noise_value
);
    import pnz_pkg::*;

    localparam int STAGES = 8;

    logic             adv;
    logic             accept;
    logic             load_we;
    logic [STAGES:1]  vld_reg;
    logic [STAGES:1]  vld_next;

    // Stage 0 signals
    idx_t             xi0;
    idx_t             xi1_0;
    idx_t             yi0;
    logic [15:0]      fx0;
    logic [15:0]      fy0;
    idx_t             load_addr;

    // Stage 1
    logic [15:0]      fx1_reg;
    logic [15:0]      fy1_reg;
    idx_t             yi1_reg;
    logic [VAL_W-1:0] pa;
    logic [VAL_W-1:0] pb;
    idx_t             a0;
    idx_t             a1;
    idx_t             b0;
    idx_t             b1;
    logic [IDX_W:0]   sum_a;
    logic [IDX_W:0]   sum_b;
    logic [31:0]      sqx;
    logic [31:0]      sqy;

    // Stage 2
    logic [15:0]      fx2_reg;
    logic [15:0]      fy2_reg;
    logic [15:0]      t2x_reg;
    logic [15:0]      t2y_reg;
    logic [VAL_W-1:0] h_aa;
    logic [VAL_W-1:0] h_ab;
    logic [VAL_W-1:0] h_ba;
    logic [VAL_W-1:0] h_bb;
    logic signed [17:0] dx0;
    logic signed [17:0] dx1;
    logic signed [17:0] dy0;
    logic signed [17:0] dy1;
    logic [31:0]      cux;
    logic [31:0]      cuy;
    logic signed [22:0] gx_raw;
    logic signed [22:0] gy_raw;

    // Stage 3
    logic [15:0]      t3x_reg;
    logic [15:0]      t3y_reg;
    logic [20:0]      gx_reg;
    logic [20:0]      gy_reg;
    logic signed [18:0] g00_reg;
    logic signed [18:0] g10_reg;
    logic signed [18:0] g01_reg;
    logic signed [18:0] g11_reg;
    logic [37:0]      ux_full;
    logic [37:0]      uy_full;
    logic [16:0]      u_next;
    logic [16:0]      v_next;

    // Stage 4
    logic [16:0]      u_reg;
    logic [16:0]      v4_reg;
    logic signed [18:0] g00_4_reg;
    logic signed [18:0] g10_4_reg;
    logic signed [18:0] g01_4_reg;
    logic signed [18:0] g11_4_reg;

    // Stage 5
    logic signed [36:0] p00_reg;
    logic signed [36:0] p10_reg;
    logic signed [36:0] p01_reg;
    logic signed [36:0] p11_reg;
    logic [16:0]      v5_reg;
    logic signed [37:0] s1;
    logic signed [37:0] s2;

    // Stage 6
    logic signed [21:0] x1_reg;
    logic signed [21:0] x2_reg;
    logic [16:0]      v6_reg;

    // Stage 7
    logic signed [39:0] q1_reg;
    logic signed [39:0] q2_reg;
    logic signed [40:0] lsum;
    logic signed [25:0] r_full;
    logic [15:0]      out_next;

    // Stage 8
    logic [15:0]      out_reg;

    // Hold the whole pipeline while the result waits
    assign adv      = !vld_reg[STAGES] || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && in_ready;
    assign load_we  = accept && (cmd == CMD_LOAD)
                      && (entry_index < VAL_W'(TABLE_ENTRIES));
    assign load_addr = idx_t'(entry_index);

    // Split the point into wrapped cell and 0.16 fraction
    always_comb
    begin
        xi0   = INT_MOD_LUT[x_coord[COORD_W-1:FRAC_BITS]];
        yi0   = INT_MOD_LUT[y_coord[COORD_W-1:FRAC_BITS]];
        xi1_0 = wrap_idx({1'b0, xi0} + (IDX_W+1)'(1));
        fx0   = 16'(x_coord[FRAC_BITS-1:0]) << (Q_BITS - FRAC_BITS);
        fy0   = 16'(y_coord[FRAC_BITS-1:0]) << (Q_BITS - FRAC_BITS);
    end

    pnz_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_ram_pa (
        .clk(clk), .we(load_we), .waddr(load_addr), .wdata(entry_value),
        .re(adv), .raddr(xi0), .rdata(pa)
    );

    pnz_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_ram_pb (
        .clk(clk), .we(load_we), .waddr(load_addr), .wdata(entry_value),
        .re(adv), .raddr(xi1_0), .rdata(pb)
    );

    // Form the corner hash addresses and square the fractions
    always_comb
    begin
        sum_a = {1'b0, VAL_MOD_LUT[pa]} + {1'b0, yi1_reg};
        sum_b = {1'b0, VAL_MOD_LUT[pb]} + {1'b0, yi1_reg};
        a0    = wrap_idx(sum_a);
        a1    = wrap_idx(sum_a + (IDX_W+1)'(1));
        b0    = wrap_idx(sum_b);
        b1    = wrap_idx(sum_b + (IDX_W+1)'(1));
        sqx   = fx1_reg * fx1_reg;
        sqy   = fy1_reg * fy1_reg;
    end

    pnz_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_ram_aa (
        .clk(clk), .we(load_we), .waddr(load_addr), .wdata(entry_value),
        .re(adv), .raddr(a0), .rdata(h_aa)
    );

    pnz_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_ram_ab (
        .clk(clk), .we(load_we), .waddr(load_addr), .wdata(entry_value),
        .re(adv), .raddr(a1), .rdata(h_ab)
    );

    pnz_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_ram_ba (
        .clk(clk), .we(load_we), .waddr(load_addr), .wdata(entry_value),
        .re(adv), .raddr(b0), .rdata(h_ba)
    );

    pnz_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_ram_bb (
        .clk(clk), .we(load_we), .waddr(load_addr), .wdata(entry_value),
        .re(adv), .raddr(b1), .rdata(h_bb)
    );

    // Cube the fractions, build the fade quadratic and the corner offsets
    always_comb
    begin
        cux    = t2x_reg * fx2_reg;
        cuy    = t2y_reg * fy2_reg;
        gx_raw = 23'(FADE_A) * $signed({7'd0, t2x_reg})
                 - 23'(FADE_B) * $signed({7'd0, fx2_reg})
                 + 23'(FADE_C * ONE_Q16);
        gy_raw = 23'(FADE_A) * $signed({7'd0, t2y_reg})
                 - 23'(FADE_B) * $signed({7'd0, fy2_reg})
                 + 23'(FADE_C * ONE_Q16);
        dx0    = $signed({2'b00, fx2_reg});
        dy0    = $signed({2'b00, fy2_reg});
        dx1    = dx0 - 18'(ONE_Q16);
        dy1    = dy0 - 18'(ONE_Q16);
    end

    // Finish the fade with rounding and limit
    always_comb
    begin
        ux_full = 38'(t3x_reg) * 38'(gx_reg) + 38'(HALF_Q16);
        uy_full = 38'(t3y_reg) * 38'(gy_reg) + 38'(HALF_Q16);
        if (ux_full[37:16] > 22'(ONE_Q16))
        begin
            u_next = 17'(ONE_Q16);
        end
        else
        begin
            u_next = ux_full[32:16];
        end
        if (uy_full[37:16] > 22'(ONE_Q16))
        begin
            v_next = 17'(ONE_Q16);
        end
        else
        begin
            v_next = uy_full[32:16];
        end
    end

    // Sum the x lerp products and round
    always_comb
    begin
        s1 = 38'(p00_reg) + 38'(p10_reg) + 38'(HALF_Q16);
        s2 = 38'(p01_reg) + 38'(p11_reg) + 38'(HALF_Q16);
    end

    // Final lerp, map to [0,1] and saturate
    always_comb
    begin
        lsum   = 41'(q1_reg) + 41'(q2_reg) + 41'(HALF_Q16);
        r_full = 26'($signed(lsum[40:16])) + 26'(ONE_Q16 + 1);
        if (r_full < 0)
        begin
            out_next = '0;
        end
        else if (r_full[25:1] > 25'd65535)
        begin
            out_next = 16'hFFFF;
        end
        else
        begin
            out_next = r_full[16:1];
        end
    end

    // Advance valid bits; load words leave no result
    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
        begin
            vld_next = {vld_reg[STAGES-1:1], accept && (cmd == CMD_EVAL)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx1_reg   <= fx0;
            fy1_reg   <= fy0;
            yi1_reg   <= yi0;

            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
            t2x_reg   <= sqx[31:16];
            t2y_reg   <= sqy[31:16];

            t3x_reg   <= cux[31:16];
            t3y_reg   <= cuy[31:16];
            gx_reg    <= (gx_raw < 0) ? '0 : gx_raw[20:0];
            gy_reg    <= (gy_raw < 0) ? '0 : gy_raw[20:0];
            g00_reg   <= grad_dot(h_aa, dx0, dy0);
            g10_reg   <= grad_dot(h_ba, dx1, dy0);
            g01_reg   <= grad_dot(h_ab, dx0, dy1);
            g11_reg   <= grad_dot(h_bb, dx1, dy1);

            u_reg     <= u_next;
            v4_reg    <= v_next;
            g00_4_reg <= g00_reg;
            g10_4_reg <= g10_reg;
            g01_4_reg <= g01_reg;
            g11_4_reg <= g11_reg;

            p00_reg   <= g00_4_reg * $signed({1'b0, 17'(ONE_Q16) - u_reg});
            p10_reg   <= g10_4_reg * $signed({1'b0, u_reg});
            p01_reg   <= g01_4_reg * $signed({1'b0, 17'(ONE_Q16) - u_reg});
            p11_reg   <= g11_4_reg * $signed({1'b0, u_reg});
            v5_reg    <= v4_reg;

            x1_reg    <= s1[37:16];
            x2_reg    <= s2[37:16];
            v6_reg    <= v5_reg;

            q1_reg    <= x1_reg * $signed({1'b0, 17'(ONE_Q16) - v6_reg});
            q2_reg    <= x2_reg * $signed({1'b0, v6_reg});

            out_reg   <= out_next;
        end
    end

    assign out_valid   = vld_reg[STAGES];
    assign noise_value = out_reg;

    // Checks
    `PNZ_ASSERT(a_load_no_result, clk, rst_n,
        accept && (cmd == CMD_LOAD) |=> !vld_reg[1], "load word entered the pipeline")
    `PNZ_ASSERT(a_stall_holds, clk, rst_n,
        !adv |=> $stable(vld_reg), "pipeline moved during a stall")
    `PNZ_ASSERT(a_result_source, clk, rst_n,
        $rose(out_valid) |-> $past(vld_reg[STAGES-1]), "result without a source word")

endmodule
